### sv/gmsm_pkg.sv
// Shared types and constants for the grid maze set merge unit.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package gmsm_pkg;

    // fixed field widths
    localparam int CELL_W  = 6;   // grid column / row
    localparam int ROOM_W  = 5;   // room column / row (cells / 2)
    localparam int LABEL_W = 10;  // set label
    localparam int COUNT_W = 11;  // set count

    // stream packing
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // request kinds carried on tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TRY   = 1'b1;

    // configuration register indexes
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // configuration reset values
    localparam logic [CELL_W-1:0] GRID_RESET = 6'd31;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_INIT = 7'b0000010,
        ST_RDA  = 7'b0000100,
        ST_RDB  = 7'b0001000,
        ST_CMP  = 7'b0010000,
        ST_SCAN = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

endpackage : gmsm_pkg

`default_nettype wire

### sv/gmsm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gmsm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule : gmsm_ram

`default_nettype wire

### sv/grid_maze_set_merge_unit.sv
// Top level of the grid maze set merge unit (Kruskal maze carving).
// Depends on gmsm_pkg and gmsm_ram.
`timescale 1ns / 1ps
`default_nettype none

// Kruskal maze carving over an odd-sized grid whose rooms sit at odd/odd
// cells. Room set labels live in one label RAM (one write, one registered
// read port). A start request writes a fresh label to every room in use,
// one room per cycle. A try request on a wall reads the two room labels
// and, when they differ, sweeps every room in use through the RAM,
// relabeling one set to the other, one room per cycle, as the single RAM
// port pair allows. A wall whose rooms already share a label skips the
// sweep, and all other try requests go straight to the result. One request
// is in work at a time; a finished result waits in the output register
// while the next request is taken.
// The label RAM is not cleared after reset; no reset pass is needed.
module grid_maze_set_merge_unit #(
    parameter int MAX_ROOMS_SIDE = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_index,
    input  wire logic [gmsm_pkg::CELL_W-1:0]      cfg_data,
    // requests
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [gmsm_pkg::IN_DATA_W-1:0]   s_tdata,  // col[5:0], row[11:6]
    input  wire logic                             s_tuser,  // mode
    // results
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [gmsm_pkg::OUT_DATA_W-1:0]       m_tdata   // opened, sets_left[11:1], done_res
);

    import gmsm_pkg::*;

    localparam int DEPTH = MAX_ROOMS_SIDE * MAX_ROOMS_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [AW-1:0] room_addr(input logic [ROOM_W-1:0] y,
                                                input logic [ROOM_W-1:0] x);
        room_addr = AW'(int'(y) * MAX_ROOMS_SIDE + int'(x));
    endfunction

    // registers
    state_t               state_reg, state_next;
    logic [CELL_W-1:0]    grid_w_reg, grid_w_next;
    logic [CELL_W-1:0]    grid_h_reg, grid_h_next;
    logic [COUNT_W-1:0]   set_total_reg, set_total_next;
    logic                 finished_reg, finished_next;
    logic                 opened_reg, opened_next;
    logic [ROOM_W-1:0]    sx_reg, sx_next;
    logic [ROOM_W-1:0]    sy_reg, sy_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic [AW-1:0]        ia_reg, ia_next;
    logic [AW-1:0]        ib_reg, ib_next;
    logic [LABEL_W-1:0]   lab_a_reg, lab_a_next;
    logic [LABEL_W-1:0]   lab_b_reg, lab_b_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // ram ports
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [LABEL_W-1:0]   ram_wr_data;
    logic [AW-1:0]        ram_rd_addr;
    logic [LABEL_W-1:0]   ram_rd_data;

    // decode
    logic [ROOM_W-1:0]    half_w, half_h, rc, rr;
    logic [CELL_W-1:0]    in_col, in_row;
    logic [ROOM_W-1:0]    hx, hy;
    logic                 is_horiz, is_vert, is_room;
    logic                 horiz_ok, vert_ok, room_ok;
    logic [COUNT_W-1:0]   total_dec;
    logic                 in_accept;
    logic                 out_free;

    // rooms in use along each axis
    assign half_w = grid_w_reg[CELL_W-1:1];
    assign half_h = grid_h_reg[CELL_W-1:1];
    assign rc = (int'(half_w) > MAX_ROOMS_SIDE) ? ROOM_W'(MAX_ROOMS_SIDE) : half_w;
    assign rr = (int'(half_h) > MAX_ROOMS_SIDE) ? ROOM_W'(MAX_ROOMS_SIDE) : half_h;

    // request fields and wall classification
    assign in_col   = s_tdata[CELL_W-1:0];
    assign in_row   = s_tdata[2*CELL_W-1:CELL_W];
    assign hx       = in_col[CELL_W-1:1];
    assign hy       = in_row[CELL_W-1:1];
    assign is_horiz = !in_row[0] && in_col[0];
    assign is_vert  = in_row[0] && !in_col[0];
    assign is_room  = in_row[0] && in_col[0];
    assign horiz_ok = (hx < rc) && (in_row >= CELL_W'(2)) && (hy < rr);
    assign vert_ok  = (hy < rr) && (in_col >= CELL_W'(2)) && (hx < rc);
    assign room_ok  = (hx < rc) && (hy < rr);

    assign total_dec = (set_total_reg != '0) ? set_total_reg - COUNT_W'(1) : '0;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // label memory
    gmsm_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_label_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        grid_w_next     = grid_w_reg;
        grid_h_next     = grid_h_reg;
        set_total_next  = set_total_reg;
        finished_next   = finished_reg;
        opened_next     = opened_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        cnt_next        = cnt_reg;
        issue_done_next = issue_done_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        lab_a_next      = lab_a_reg;
        lab_b_next      = lab_b_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = room_addr(sy_reg, sx_reg);
        ram_wr_data     = cnt_reg[LABEL_W-1:0];
        ram_rd_addr     = ia_reg;

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_w_next = cfg_data;
                REG_GRID_HEIGHT: grid_h_next = cfg_data;
                default:         grid_w_next = grid_w_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    opened_next = 1'b0;
                    sx_next     = '0;
                    sy_next     = '0;
                    cnt_next    = '0;
                    if (s_tuser == MODE_START)
                    begin
                        finished_next = 1'b0;
                        if (rc == '0 || rr == '0)
                        begin
                            set_total_next = '0;
                            state_next     = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_INIT;
                        end
                    end
                    else if (finished_reg)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (is_horiz && horiz_ok)
                    begin
                        ia_next    = room_addr(hy - ROOM_W'(1), hx);
                        ib_next    = room_addr(hy, hx);
                        state_next = ST_RDA;
                    end
                    else if (is_vert && vert_ok)
                    begin
                        ia_next    = room_addr(hy, hx - ROOM_W'(1));
                        ib_next    = room_addr(hy, hx);
                        state_next = ST_RDA;
                    end
                    else
                    begin
                        // room cell inside the grid still runs the done check
                        if (is_room && room_ok && set_total_reg <= COUNT_W'(1))
                        begin
                            finished_next = 1'b1;
                        end
                        state_next = ST_FIN;
                    end
                end
            end

            ST_INIT:
            begin
                // fresh label per room, row-major
                ram_wr_en = 1'b1;
                cnt_next  = cnt_reg + COUNT_W'(1);
                if (sx_reg == rc - ROOM_W'(1))
                begin
                    sx_next = '0;
                    sy_next = sy_reg + ROOM_W'(1);
                    if (sy_reg == rr - ROOM_W'(1))
                    begin
                        set_total_next = cnt_reg + COUNT_W'(1);
                        state_next     = ST_FIN;
                    end
                end
                else
                begin
                    sx_next = sx_reg + ROOM_W'(1);
                end
            end

            ST_RDA:
            begin
                ram_rd_addr = ia_reg;
                state_next  = ST_RDB;
            end

            ST_RDB:
            begin
                lab_a_next  = ram_rd_data;
                ram_rd_addr = ib_reg;
                state_next  = ST_CMP;
            end

            ST_CMP:
            begin
                lab_b_next      = ram_rd_data;
                issue_done_next = 1'b0;
                if (ram_rd_data != lab_a_reg)
                begin
                    opened_next    = 1'b1;
                    set_total_next = total_dec;
                    finished_next  = (total_dec <= COUNT_W'(1));
                    state_next     = ST_SCAN;
                end
                else
                begin
                    finished_next = (set_total_reg <= COUNT_W'(1));
                    state_next    = ST_FIN;
                end
            end

            ST_SCAN:
            begin
                // read one room per cycle, write back the one read last cycle
                if (!issue_done_reg)
                begin
                    ram_rd_addr    = room_addr(sy_reg, sx_reg);
                    pend_next      = 1'b1;
                    pend_addr_next = room_addr(sy_reg, sx_reg);
                    if (sx_reg == rc - ROOM_W'(1))
                    begin
                        sx_next = '0;
                        sy_next = sy_reg + ROOM_W'(1);
                        if (sy_reg == rr - ROOM_W'(1))
                        begin
                            issue_done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        sx_next = sx_reg + ROOM_W'(1);
                    end
                end
                ram_wr_addr = pend_addr_reg;
                ram_wr_data = lab_b_reg;
                ram_wr_en   = pend_reg && (ram_rd_data == lab_a_reg);
                if (issue_done_reg && pend_reg)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                // hand the result to the output register
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_DATA_W'({finished_reg, set_total_reg, opened_reg});
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            grid_w_reg     <= GRID_RESET;
            grid_h_reg     <= GRID_RESET;
            set_total_reg  <= '0;
            finished_reg   <= 1'b0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            cnt_reg        <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            grid_w_reg     <= grid_w_next;
            grid_h_reg     <= grid_h_next;
            set_total_reg  <= set_total_next;
            finished_reg   <= finished_next;
            sx_reg         <= sx_next;
            sy_reg         <= sy_next;
            cnt_reg        <= cnt_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        opened_reg    <= opened_next;
        pend_addr_reg <= pend_addr_next;
        ia_reg        <= ia_next;
        ib_reg        <= ib_next;
        lab_a_reg     <= lab_a_next;
        lab_b_reg     <= lab_b_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule : grid_maze_set_merge_unit

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for grid_maze_set_merge_unit (Kruskal maze carving).
// Needs gmsm_pkg and the unit's RTL; runs a directed table, then random mazes
// checked against an in-bench label/set predictor, with random stalls.
`timescale 1ns / 1ps

module tb_top;

    import gmsm_pkg::*;

    localparam int MAX_SIDE   = 32;
    localparam int IDLE_LIMIT = 50000;
    localparam int HOLD_LEN   = 400;
    localparam int RAND_ITEMS = 500;

    // one request: mode on tuser, col and row on tdata
    typedef struct packed {
        logic              mode;
        logic [CELL_W-1:0] col;
        logic [CELL_W-1:0] row;
    } maze_req_t;

    // one result, laid out as on m_tdata from the top bit down
    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] sets;
        logic               opened;
    } carve_res_t;

    typedef struct packed {
        maze_req_t  req;
        bit         typed;
        carve_res_t want;
    } req_item_t;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    // directed step; a config row carries width in col and height in row
    typedef struct packed {
        row_kind_t kind;
        req_item_t item;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = REG_GRID_WIDTH;
    logic [CELL_W-1:0]     cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // col[5:0], row[11:6]
    logic                  s_tuser = 1'b0; // mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // opened, sets_left[11:1], done_res

    grid_maze_set_merge_unit #(
        .MAX_ROOMS_SIDE(MAX_SIDE)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor state
    logic [CELL_W-1:0]  grid_w = GRID_RESET;
    logic [CELL_W-1:0]  grid_h = GRID_RESET;
    logic [LABEL_W-1:0] room_lbl [0:MAX_SIDE*MAX_SIDE-1];
    bit                 room_seen [0:MAX_SIDE*MAX_SIDE-1];
    logic [COUNT_W-1:0] set_cnt = '0;
    bit                 maze_done = 1'b0;

    req_item_t  pend_q[$];
    carve_res_t carve_q[$];
    dir_row_t   dir_tab[$];

    int  err_cnt = 0;
    int  n_reqs = 0;
    int  n_opened = 0;
    int  n_finished = 0;
    int  n_phases = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  idle_cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int rooms_on(logic [CELL_W-1:0] cells);
        int n;
        n = int'(cells >> 1);
        return (n > MAX_SIDE) ? MAX_SIDE : n;
    endfunction

    // apply one request to the predictor and return its result
    function automatic carve_res_t carve_step(maze_req_t r);
        carve_res_t res;
        int rc, rr, n, ia, ib, x, y, yy, xx;
        bit wall, check;
        logic [LABEL_W-1:0] la, lb;
        rc = rooms_on(grid_w);
        rr = rooms_on(grid_h);
        res = '0;
        wall = 1'b0;
        check = 1'b0;
        ia = 0;
        ib = 0;
        if (r.mode == MODE_START)
        begin
            n = 0;
            for (yy = 0; yy < rr; yy++)
                for (xx = 0; xx < rc; xx++)
                begin
                    room_lbl[yy*MAX_SIDE+xx] = n[LABEL_W-1:0];
                    room_seen[yy*MAX_SIDE+xx] = 1'b1;
                    n++;
                end
            set_cnt = n[COUNT_W-1:0];
            maze_done = 1'b0;
        end
        else if (!maze_done)
        begin
            x = int'(r.col >> 1);
            y = int'(r.row >> 1);
            // horizontal wall joins the room above into the one below
            if (!r.row[0] && r.col[0])
            begin
                if (x < rc && r.row >= 2 && y < rr)
                begin
                    ia = (y - 1) * MAX_SIDE + x;
                    ib = y * MAX_SIDE + x;
                    wall = 1'b1;
                end
            end
            // vertical wall joins the room left into the one right
            else if (r.row[0] && !r.col[0])
            begin
                if (y < rr && r.col >= 2 && x < rc)
                begin
                    ia = y * MAX_SIDE + x - 1;
                    ib = y * MAX_SIDE + x;
                    wall = 1'b1;
                end
            end
            // a room cell inside the grid only triggers the done check
            else if (r.row[0] && r.col[0])
                check = (x < rc) && (y < rr);
            if (wall)
            begin
                la = room_lbl[ia];
                lb = room_lbl[ib];
                if (la != lb)
                begin
                    if (set_cnt != 0)
                        set_cnt = set_cnt - COUNT_W'(1);
                    for (yy = 0; yy < rr; yy++)
                        for (xx = 0; xx < rc; xx++)
                            if (room_lbl[yy*MAX_SIDE+xx] == la)
                                room_lbl[yy*MAX_SIDE+xx] = lb;
                    res.opened = 1'b1;
                end
                check = 1'b1;
            end
            if (check && set_cnt <= 1)
                maze_done = 1'b1;
        end
        res.sets = set_cnt;
        res.done = maze_done;
        return res;
    endfunction

    // request side: hold valid until taken, predict on every accepted request
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                carve_res_t want;
                want = carve_step(pend_q[0].req);
                if (pend_q[0].typed)
                    want = pend_q[0].want;
                carve_q.insert(carve_q.size(), want);
                void'(pend_q.pop_front());
                n_reqs++;
            end
            if (pend_q.size() != 0 && (quiet || $urandom_range(99) >= 28))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, pend_q[0].req.row, pend_q[0].req.col};
                s_tuser  <= pend_q[0].req.mode;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side: compare against the oldest expectation, random backpressure
    always @(posedge clk)
    begin
        carve_res_t got, want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(carve_res_t)-1:0];
                if (carve_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result with nothing expected: opened=%0d sets=%0d done=%0d",
                                 $time, got.opened, got.sets, got.done);
                end
                else
                begin
                    want = carve_q.pop_front();
                    if (got.opened !== want.opened || got.sets !== want.sets
                        || got.done !== want.done)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: mismatch exp opened=%0d sets=%0d done=%0d, got opened=%0d sets=%0d done=%0d",
                                     $time, want.opened, want.sets, want.done,
                                     got.opened, got.sets, got.done);
                    end
                    if (got.opened === 1'b1)
                        n_opened++;
                    if (got.done === 1'b1 && want.done && !want.opened && want.sets <= 1)
                        n_finished++;
                end
            end
            // long receiver hold-off so the unit backs up and stalls its input
            if (hold_req)
            begin
                hold_left = HOLD_LEN;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= quiet || ($urandom_range(99) >= 28);
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, carve_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic add_row(row_kind_t kind, logic mode, logic [CELL_W-1:0] col,
                           logic [CELL_W-1:0] row, bit typed, logic opened,
                           logic [COUNT_W-1:0] sets, logic done);
        dir_row_t d;
        d.kind = kind;
        d.item.req.mode = mode;
        d.item.req.col = col;
        d.item.req.row = row;
        d.item.typed = typed;
        d.item.want.opened = opened;
        d.item.want.sets = sets;
        d.item.want.done = done;
        dir_tab.insert(dir_tab.size(), d);
    endtask

    task automatic queue_req(logic mode, logic [CELL_W-1:0] col, logic [CELL_W-1:0] row);
        req_item_t it;
        it = '0;
        it.req.mode = mode;
        it.req.col = col;
        it.req.row = row;
        pend_q.insert(pend_q.size(), it);
    endtask

    // wait until every request is taken and answered, then let the unit settle
    task automatic wait_drained();
        while (pend_q.size() != 0 || carve_q.size() != 0 || s_tvalid)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CELL_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_GRID_WIDTH)
            grid_w = val;
        else
            grid_h = val;
        @(negedge clk);
    endtask

    initial
    begin
        maze_req_t walls[$];
        maze_req_t tmp;
        logic [CELL_W-1:0] w, h;
        int rc, rr, pick, j, k, take, rand_sent;
        bit fresh;

        // directed table: reset shape 31x31 has 15x15 rooms
        add_row(ROW_REQ, MODE_START, 6'd0,  6'd0,  1, 1'b0, 11'd225, 1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd0,  6'd0,  1, 1'b0, 11'd225, 1'b0); // pillar
        add_row(ROW_REQ, MODE_TRY,   6'd0,  6'd1,  1, 1'b0, 11'd225, 1'b0); // left border
        add_row(ROW_REQ, MODE_TRY,   6'd1,  6'd0,  1, 1'b0, 11'd225, 1'b0); // top border
        add_row(ROW_REQ, MODE_TRY,   6'd1,  6'd2,  1, 1'b1, 11'd224, 1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd1,  6'd2,  1, 1'b0, 11'd224, 1'b0); // same set now
        add_row(ROW_REQ, MODE_TRY,   6'd1,  6'd1,  1, 1'b0, 11'd224, 1'b0); // room cell
        add_row(ROW_REQ, MODE_TRY,   6'd63, 6'd63, 1, 1'b0, 11'd224, 1'b0); // outside grid
        add_row(ROW_REQ, MODE_TRY,   6'd2,  6'd1,  1, 1'b1, 11'd223, 1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd62, 6'd62, 1, 1'b0, 11'd223, 1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd30, 6'd29, 1, 1'b0, 11'd223, 1'b0); // right border
        add_row(ROW_REQ, MODE_TRY,   6'd28, 6'd29, 1, 1'b1, 11'd222, 1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd7,  6'd4,  0, 1'b0, 11'd0,   1'b0);
        // smallest grid: a single room finishes on the first done check
        add_row(ROW_CFG, MODE_START, 6'd3,  6'd3,  0, 1'b0, 11'd0,   1'b0);
        add_row(ROW_REQ, MODE_START, 6'd0,  6'd0,  1, 1'b0, 11'd1,   1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd1,  6'd2,  1, 1'b0, 11'd1,   1'b0); // border, no check
        add_row(ROW_REQ, MODE_TRY,   6'd1,  6'd1,  1, 1'b0, 11'd1,   1'b1);
        add_row(ROW_REQ, MODE_TRY,   6'd2,  6'd1,  1, 1'b0, 11'd1,   1'b1); // already finished
        // largest grid: 31x31 rooms
        add_row(ROW_CFG, MODE_START, 6'd63, 6'd63, 0, 1'b0, 11'd0,   1'b0);
        add_row(ROW_REQ, MODE_START, 6'd0,  6'd0,  1, 1'b0, 11'd961, 1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd61, 6'd62, 1, 1'b0, 11'd961, 1'b0); // bottom border
        add_row(ROW_REQ, MODE_TRY,   6'd61, 6'd60, 1, 1'b1, 11'd960, 1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd60, 6'd61, 1, 1'b1, 11'd959, 1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd33, 6'd17, 0, 1'b0, 11'd0,   1'b0);
        // even register values are taken as given
        add_row(ROW_CFG, MODE_START, 6'd4,  6'd6,  0, 1'b0, 11'd0,   1'b0);
        add_row(ROW_REQ, MODE_START, 6'd0,  6'd0,  1, 1'b0, 11'd6,   1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd4,  6'd5,  0, 1'b0, 11'd0,   1'b0);
        add_row(ROW_REQ, MODE_TRY,   6'd3,  6'd4,  0, 1'b0, 11'd0,   1'b0);

        wait (rst_n === 1'b1);
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(REG_GRID_WIDTH, dir_tab[i].item.req.col);
                write_reg(REG_GRID_HEIGHT, dir_tab[i].item.req.row);
            end
            else
                pend_q.insert(pend_q.size(), dir_tab[i].item);
        end
        wait_drained();

        // random mazes: mostly shuffled wall sequences, some noise mixed in
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                w = CELL_W'(2 * $urandom_range(1, 6) + 1);
                h = CELL_W'(2 * $urandom_range(1, 6) + 1);
            end
            else if (pick < 80)
            begin
                w = CELL_W'($urandom_range(3, 63));
                h = CELL_W'($urandom_range(3, 63));
            end
            else if (pick < 90)
            begin
                w = $urandom_range(1) ? 6'd63 : 6'd3;
                h = $urandom_range(1) ? 6'd63 : 6'd3;
            end
            else
            begin
                w = CELL_W'(2 * $urandom_range(1, 31) + 1);
                h = CELL_W'(2 * $urandom_range(1, 31) + 1);
            end
            if ($urandom_range(1))
            begin
                write_reg(REG_GRID_WIDTH, w);
                write_reg(REG_GRID_HEIGHT, h);
            end
            else
            begin
                write_reg(REG_GRID_HEIGHT, h);
                write_reg(REG_GRID_WIDTH, w);
            end
            rc = rooms_on(w);
            rr = rooms_on(h);

            // one phase without idling, one with a long receiver hold-off
            quiet = (n_phases == 3);
            if (n_phases == 1)
                hold_req = 1'b1;
            n_phases++;

            // a fresh start is needed unless every room of this shape has a label
            fresh = 1'b1;
            for (j = 0; j < rr; j++)
                for (k = 0; k < rc; k++)
                    if (!room_seen[j*MAX_SIDE+k])
                        fresh = 1'b0;
            if (!fresh || $urandom_range(1))
            begin
                queue_req(MODE_START, CELL_W'($urandom_range(63)),
                          CELL_W'($urandom_range(63)));
                rand_sent++;
            end

            // all interior walls of the shape, shuffled
            walls.delete();
            for (j = 1; j < rr; j++)
                for (k = 0; k < rc; k++)
                begin
                    tmp.mode = MODE_TRY;
                    tmp.col = CELL_W'(2 * k + 1);
                    tmp.row = CELL_W'(2 * j);
                    walls.insert(walls.size(), tmp);
                end
            for (j = 0; j < rr; j++)
                for (k = 1; k < rc; k++)
                begin
                    tmp.mode = MODE_TRY;
                    tmp.col = CELL_W'(2 * k);
                    tmp.row = CELL_W'(2 * j + 1);
                    walls.insert(walls.size(), tmp);
                end
            for (j = walls.size() - 1; j > 0; j--)
            begin
                k = $urandom_range(j);
                tmp = walls[j];
                walls[j] = walls[k];
                walls[k] = tmp;
            end

            // big grids sweep every room per join, so only a few walls there
            take = (rc * rr > 64) ? 10 : 120;
            if (take > walls.size())
                take = walls.size();
            if (take > RAND_ITEMS - rand_sent)
                take = RAND_ITEMS - rand_sent;
            for (j = 0; j < take; j++)
            begin
                if ($urandom_range(99) < 15)
                begin
                    queue_req(($urandom_range(9) == 0) ? MODE_START : MODE_TRY,
                              CELL_W'($urandom_range(63)), CELL_W'($urandom_range(63)));
                    rand_sent++;
                end
                queue_req(walls[j].mode, walls[j].col, walls[j].row);
                rand_sent++;
            end
            // a few stray cells even when the shape has no walls
            for (j = 0; j < 3; j++)
            begin
                queue_req(MODE_TRY, CELL_W'($urandom_range(63)), CELL_W'($urandom_range(63)));
                rand_sent++;
            end
            wait_drained();
        end
        quiet = 1'b0;

        wait_drained();
        repeat (64) @(negedge clk);
        if (carve_q.size() != 0)
        begin
            err_cnt += carve_q.size();
            $display("%0d expected results never arrived", carve_q.size());
        end

        $display("covered %0d requests over %0d random grid shapes plus the directed table",
                 n_reqs, n_phases);
        $display("walls opened: %0d, finished-maze results seen: %0d, mismatches: %0d",
                 n_opened, n_finished, err_cnt);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
